// ----- hdl/tfcd_pkg.sv -----
// Package holding the shared types and constants of the trailer-framed CRC-16 deframer.
package tfcd_pkg;

    // Window geometry and frame layout.
    localparam int WinLen    = 20;
    localparam int CrcSpan   = 18;
    localparam int WinIdxW   = $clog2(WinLen);
    localparam int MarkPosA  = 16;
    localparam int MarkPosB  = 17;
    localparam int CrcLoPos  = 18;
    localparam int CrcHiPos  = 19;

    // CRC-16 parameters: polynomial 0x1021, preset 0xFFFF, MSB first, no final XOR.
    localparam logic [15:0] CrcPoly  = 16'h1021;
    localparam logic [15:0] CrcInit  = 16'hFFFF;
    localparam logic [7:0]  MarkByte = 8'h5A;

    // Result payload width: header, sequence, idle count, status, X, Y.
    localparam int OutDataW = 128;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_CHECK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic shift;     // shift the accepted byte into the window
        logic crc_init;  // preset the CRC and clear the byte counter
        logic crc_step;  // fold one window byte into the CRC
        logic load_out;  // capture the frame fields into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic crc_last;  // the current step folds the last covered byte
        logic frame_ok;  // markers and CRC both match
        logic out_busy;  // a result is held and not taken this cycle
    } t_stat;

endpackage

// ----- hdl/tfcd_datapath.sv -----
// Datapath: byte window, byte-serial CRC-16 unit, frame check and output register.
module tfcd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tfcd_pkg::t_cmd                i_cmd,
    output tfcd_pkg::t_stat               o_stat,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [tfcd_pkg::OutDataW-1:0] o_m_tdata
);

    // Fold one byte into the CRC, one bit per inner step, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ tfcd_pkg::CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic [7:0]                     r_win [tfcd_pkg::WinLen];
    logic [15:0]                    r_crc;
    logic [15:0]                    n_crc;
    logic [tfcd_pkg::WinIdxW-1:0]   r_idx;
    logic [tfcd_pkg::WinIdxW-1:0]   n_idx;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic [tfcd_pkg::OutDataW-1:0]  r_out_data;
    logic [15:0]                    sent_crc;

    // Window shifts toward position zero; the newest byte enters at the top.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tfcd_pkg::WinLen; i++) begin
                r_win[i] <= 8'h00;
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < tfcd_pkg::WinLen - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[tfcd_pkg::WinLen-1] <= i_rx_byte;
        end
    end

    // CRC accumulator and byte counter, one window byte per step.
    always_comb begin
        n_crc = r_crc;
        n_idx = r_idx;
        if (i_cmd.crc_init) begin
            n_crc = tfcd_pkg::CrcInit;
            n_idx = '0;
        end else if (i_cmd.crc_step) begin
            n_crc = crc_byte(r_crc, r_win[r_idx]);
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= tfcd_pkg::CrcInit;
            r_idx <= '0;
        end else begin
            r_crc <= n_crc;
            r_idx <= n_idx;
        end
    end

    // Frame check against the little-endian trailer and the two marker bytes.
    assign sent_crc = {r_win[tfcd_pkg::CrcHiPos], r_win[tfcd_pkg::CrcLoPos]};

    assign o_stat.crc_last = (r_idx == tfcd_pkg::WinIdxW'(tfcd_pkg::CrcSpan - 1));
    assign o_stat.frame_ok = (r_win[tfcd_pkg::MarkPosA] == tfcd_pkg::MarkByte) &&
                             (r_win[tfcd_pkg::MarkPosB] == tfcd_pkg::MarkByte) &&
                             (sent_crc == r_crc);
    assign o_stat.out_busy = r_out_valid && !i_m_tready;

    // Output register: holds one result until its transfer completes.
    always_comb begin
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_m_tready) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {r_win[12], r_win[13], r_win[14], r_win[15],
                           r_win[8],  r_win[9],  r_win[10], r_win[11],
                           r_win[7],
                           r_win[3],  r_win[4],  r_win[5],  r_win[6],
                           r_win[2],
                           r_win[0],  r_win[1]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- hdl/tfcd_ctrl.sv -----
// Controller: sequences byte intake, the CRC pass and the frame decision.
module tfcd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  tfcd_pkg::t_stat  i_stat,
    output tfcd_pkg::t_cmd   o_cmd
);

    tfcd_pkg::t_state r_state;
    tfcd_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tfcd_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = tfcd_pkg::ST_CRC;
                end
            end
            tfcd_pkg::ST_CRC: begin
                if (i_stat.crc_last) begin
                    n_state = tfcd_pkg::ST_CHECK;
                end
            end
            tfcd_pkg::ST_CHECK: begin
                // A good frame waits here while the previous result is still held.
                if (!i_stat.frame_ok || !i_stat.out_busy) begin
                    n_state = tfcd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tfcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            tfcd_pkg::ST_IDLE: begin
                o_s_tready     = 1'b1;
                o_cmd.shift    = i_s_tvalid;
                o_cmd.crc_init = i_s_tvalid;
            end
            tfcd_pkg::ST_CRC: begin
                o_cmd.crc_step = 1'b1;
            end
            tfcd_pkg::ST_CHECK: begin
                o_cmd.load_out = i_stat.frame_ok && !i_stat.out_busy;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/trailer_framed_crc16_deframer.sv -----
// Top level of the trailer-framed CRC-16 deframer: controller, datapath and checks.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] rx_byte
//  m_axis    out        tdata[127:0] header_word, sequence_byte, idle_count,
//                       status_byte, x_word, y_word (lowest bits first)
//
// Each accepted byte is first shifted into the window; the byte-serial CRC unit then
// runs over window bytes 0 to 17, and the frame decision follows.
// The CRC unit folds one byte per cycle.
// Reset is synchronous and clears the window to zeros; no clearing pass is needed.
// A good frame is held in the output register; if a previous result is still
// waiting there, the decision step stalls until that transfer completes.
module trailer_framed_crc16_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // [7:0] rx_byte
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [15:0] header_word, [23:16] sequence_byte, [55:24] idle_count,
    // [63:56] status_byte, [95:64] x_word, [127:96] y_word
    output logic [tfcd_pkg::OutDataW-1:0] o_m_axis_tdata
);

    tfcd_pkg::t_cmd  cmd;
    tfcd_pkg::t_stat stat;

    tfcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tfcd_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_rx_byte  (i_s_axis_tdata),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata)
    );

    // An accepted byte keeps the intake closed while its frame check runs.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted during a frame check");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("pending result overwritten");

    // A result appears only after a capture command.
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(cmd.load_out))
        else $error("result raised without a capture");

    // The window never shifts during the CRC pass.
    a_no_shift_in_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.crc_step |-> !cmd.shift)
        else $error("window shifted during CRC pass");

endmodule
